[rtl/core/tacr_pkg.sv]
// Shared types and constants for the three-axis average change reporter.
`default_nettype none

package tacr_pkg;

  localparam int unsigned WINDOW_DEF = 5;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned RATE_W    = 22;
  localparam int unsigned THR_W     = 22;
  localparam int unsigned SENT_W    = 25;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned AXES      = 3;

  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_RADIX = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0]        PERIOD_RESET = '0;
  localparam logic [THR_W-1:0]         THR_RESET    = THR_W'(1000);
  localparam logic signed [SENT_W-1:0] SENT_RESET   = -SENT_W'(9999000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_SIGN,
    ST_CHECK
  } state_e;

  typedef struct packed {
    logic take_time;
    logic take_sample;
    logic ring_upd;
    logic div_load;
    logic div_step;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic period_ok;
    logic sample_ok;
    logic div_last;
    logic moved;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/three_axis_average_change_reporter.sv]
// Top level of the three-axis windowed average change reporter.
`default_nettype none

// Takes one timestamped gyro beat per handshake. A beat arriving before
// period_ms has elapsed, or with read_ok low, is accepted and dropped. A
// taken sample holds the input stalled while the controller steps through
// ST_READ, ST_LOAD, ST_DIV, ST_SIGN and ST_CHECK; the length of ST_DIV is
// set by the three per-axis dividers, which resolve four quotient bits per
// cycle. The ring itself is a RAM read before a running-sum update and
// written in the same cycle as that update. A report waits in the output
// register, and the busy sequence is extended only if a new report finds
// that register still occupied and stalled. Config writes are always ready and must be issued while the block is idle.

module three_axis_average_change_reporter import tacr_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]     cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [TIME_W-1:0]        now_ms_i,
  input  wire logic                     read_ok_i,
  input  wire logic signed [RATE_W-1:0] rate_x_i,
  input  wire logic signed [RATE_W-1:0] rate_y_i,
  input  wire logic signed [RATE_W-1:0] rate_z_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [RATE_W-1:0]      mean_x_o,
  output logic signed [RATE_W-1:0]      mean_y_o,
  output logic signed [RATE_W-1:0]      mean_z_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tacr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tacr_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .now_ms_i    (now_ms_i),
    .read_ok_i   (read_ok_i),
    .rate_x_i    (rate_x_i),
    .rate_y_i    (rate_y_i),
    .rate_z_i    (rate_z_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mean_x_o    (mean_x_o),
    .mean_y_o    (mean_y_o),
    .mean_z_o    (mean_z_o)
  );

endmodule

`default_nettype wire

[rtl/core/tacr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tacr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/tacr_div.sv]
// Signed sum by fill count divider, radix-16 restoring, truncates toward zero.
`default_nettype none

module tacr_div import tacr_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF,
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1),
  localparam int unsigned SUM_W   = RATE_W + CNT_W,
  localparam int unsigned DIV_CYC = (SUM_W + DIV_RADIX - 1) / DIV_RADIX,
  localparam int unsigned DIV_W   = DIV_CYC * DIV_RADIX
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_i,
  input  wire logic                     step_i,
  input  wire logic signed [SUM_W-1:0]  dividend_i,
  input  wire logic        [CNT_W-1:0]  divisor_i,
  output logic signed      [RATE_W-1:0] quot_o
);

  logic [DIV_W-1:0]  dvd_q, dvd_d, dvd_step;
  logic [CNT_W:0]    rem_q, rem_d, rem_step;
  logic              neg_q;
  logic [SUM_W-1:0]  mag;
  logic [RATE_W-1:0] qmag;
  logic signed [RATE_W-1:0] quot_q;

  assign mag = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);

  always_comb begin
    rem_step = rem_q;
    dvd_step = dvd_q;
    for (int k = 0; k < DIV_RADIX; k++) begin
      rem_step = {rem_step[CNT_W-1:0], dvd_step[DIV_W-1]};
      dvd_step = {dvd_step[DIV_W-2:0], 1'b0};
      if (rem_step >= {1'b0, divisor_i}) begin
        rem_step    = rem_step - {1'b0, divisor_i};
        dvd_step[0] = 1'b1;
      end
    end
  end

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (load_i) begin
      dvd_d = DIV_W'(mag);
      rem_d = '0;
    end else if (step_i) begin
      dvd_d = dvd_step;
      rem_d = rem_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
    end else if (load_i) begin
      neg_q <= dividend_i[SUM_W-1];
    end
  end

  assign qmag = dvd_q[RATE_W-1:0];

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    quot_q <= neg_q ? $signed(-qmag) : $signed(qmag);
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

[rtl/core/tacr_datapath.sv]
// Datapath: config registers, sample ring, running sums, dividers, report logic.
`default_nettype none

module tacr_datapath import tacr_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF,
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1),
  localparam int unsigned SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int unsigned SUM_W   = RATE_W + CNT_W,
  localparam int unsigned DIV_CYC = (SUM_W + DIV_RADIX - 1) / DIV_RADIX,
  localparam int unsigned DC_W    = $clog2(DIV_CYC),
  localparam int unsigned DIFF_W  = SENT_W + 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]     cfg_data_i,
  input  wire logic [TIME_W-1:0]        now_ms_i,
  input  wire logic                     read_ok_i,
  input  wire logic signed [RATE_W-1:0] rate_x_i,
  input  wire logic signed [RATE_W-1:0] rate_y_i,
  input  wire logic signed [RATE_W-1:0] rate_z_i,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [RATE_W-1:0]      mean_x_o,
  output logic signed [RATE_W-1:0]      mean_y_o,
  output logic signed [RATE_W-1:0]      mean_z_o
);

  logic [TIME_W-1:0] period_q;
  logic [THR_W-1:0]  thr_q;
  logic [TIME_W-1:0] last_q;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              full;
  logic [DC_W-1:0]   div_cnt_q;
  logic              out_valid_q;
  logic [TIME_W-1:0] elapsed;

  logic signed [RATE_W-1:0] rate_in [AXES];
  logic signed [RATE_W-1:0] smp_q   [AXES];
  logic signed [RATE_W-1:0] old_v   [AXES];
  logic signed [RATE_W-1:0] quot    [AXES];
  logic signed [RATE_W-1:0] mean_q  [AXES];
  logic signed [SUM_W-1:0]  sum_q   [AXES];
  logic signed [SENT_W-1:0] sent_q  [AXES];
  logic [AXES-1:0]          moved;

  logic [AXES*RATE_W-1:0] ram_wdata, ram_rdata;
  logic signed [DIFF_W-1:0] thr_s;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      thr_q    <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PERIOD:    period_q <= cfg_data_i[TIME_W-1:0];
        CFG_THRESHOLD: thr_q    <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign elapsed = now_ms_i - last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (cmd_i.take_time) begin
      last_q <= now_ms_i;
    end
  end

  // ring bookkeeping
  assign full   = (fill_q == CNT_W'(WINDOW));
  assign slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
  assign fill_d = full ? fill_q : fill_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.ring_upd) begin
      slot_q <= slot_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DC_W'(1);
    end
  end

  assign rate_in[0] = rate_x_i;
  assign rate_in[1] = rate_y_i;
  assign rate_in[2] = rate_z_i;

  tacr_ram #(
    .WIDTH (AXES * RATE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ring_upd),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.take_sample),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  assign thr_s = $signed(DIFF_W'(thr_q));

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    logic signed [DIFF_W-1:0] diff;

    assign ram_wdata[a*RATE_W +: RATE_W] = smp_q[a];
    // while the ring is not yet full, the value leaving the window is taken as zero
    assign old_v[a] = full ? $signed(ram_rdata[a*RATE_W +: RATE_W]) : '0;

    always_ff @(posedge clk_i) begin
      if (cmd_i.take_sample) begin
        smp_q[a] <= rate_in[a];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sum_q[a]  <= '0;
        sent_q[a] <= SENT_RESET;
      end else begin
        if (cmd_i.ring_upd) begin
          sum_q[a] <= sum_q[a] + SUM_W'(smp_q[a]) - SUM_W'(old_v[a]);
        end
        if (cmd_i.report) begin
          sent_q[a] <= SENT_W'(quot[a]);
        end
      end
    end

    tacr_div #(
      .WINDOW (WINDOW)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (cmd_i.div_load),
      .step_i     (cmd_i.div_step),
      .dividend_i (sum_q[a]),
      .divisor_i  (fill_q),
      .quot_o     (quot[a])
    );

    assign diff     = DIFF_W'(quot[a]) - DIFF_W'(sent_q[a]);
    assign moved[a] = (diff > thr_s) || (diff < -thr_s);

    always_ff @(posedge clk_i) begin
      if (cmd_i.report) begin
        mean_q[a] <= quot[a];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.report) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_x_o    = mean_q[0];
  assign mean_y_o    = mean_q[1];
  assign mean_z_o    = mean_q[2];

  assign sts_o.period_ok = (elapsed >= period_q);
  assign sts_o.sample_ok = read_ok_i;
  assign sts_o.div_last  = (div_cnt_q == DC_W'(DIV_CYC - 1));
  assign sts_o.moved     = |moved;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

[rtl/core/tacr_ctrl.sv]
// Controller state machine sequencing one sample through ring, divide and report.
`default_nettype none

module tacr_ctrl import tacr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.period_ok && sts_i.sample_ok) begin
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (!sts_i.moved || sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && sts_i.period_ok) begin
          cmd_o.take_time   = 1'b1;
          cmd_o.take_sample = sts_i.sample_ok;
        end
      end
      ST_READ:  cmd_o.ring_upd = 1'b1;
      ST_LOAD:  cmd_o.div_load = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_SIGN:  ;
      ST_CHECK: cmd_o.report = sts_i.moved && sts_i.out_free;
      default:  ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/tacr_checker.sv]
// Port-level assertions for the reporter, bound to the top level.
`default_nettype none

module tacr_checker import tacr_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_stall_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic signed [RATE_W-1:0] mean_x_o,
  input wire logic signed [RATE_W-1:0] mean_y_o,
  input wire logic signed [RATE_W-1:0] mean_z_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(mean_x_o) && $stable(mean_y_o) && $stable(mean_z_o))
    else $error("stalled result beat changed");

  // a report only comes out of the busy sequence that follows a taken sample
  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a preceding busy cycle");

  a_report_busy2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o, 2))
    else $error("result appeared too soon after input");

endmodule

bind three_axis_average_change_reporter tacr_checker u_checker (.*);

`default_nettype wire
